>>> design/arpc_pkg.sv
package arpc_pkg;

  localparam int CACHE_ENTRIES = 8;
  localparam int IDX_W = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(CACHE_ENTRIES + 1);

  localparam int MAC_W = 48;
  localparam int IP_W  = 32;
  localparam int CFG_IDX_W = 1;

  // item opcodes
  localparam logic [1:0] OP_RX       = 2'd0;
  localparam logic [1:0] OP_LOOKUP   = 2'd1;
  localparam logic [1:0] OP_SEND_REQ = 2'd2;

  // ARP operation codes
  localparam logic [15:0] RX_ARP_REQUEST = 16'd1;
  localparam logic [15:0] RX_ARP_REPLY   = 16'd2;
  localparam logic [1:0]  FR_NONE        = 2'd0;
  localparam logic [1:0]  FR_REQUEST     = 2'd1;
  localparam logic [1:0]  FR_REPLY       = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_OWN_MAC = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OWN_IP  = 1'd1;

  localparam logic [MAC_W-1:0] MAC_BROADCAST = '1;

  typedef struct packed {
    logic             send_frame;
    logic [1:0]       frame_operation;
    logic [MAC_W-1:0] frame_dest_mac;
    logic [MAC_W-1:0] frame_target_mac;
    logic [IP_W-1:0]  frame_target_ip;
    logic             found;
    logic [MAC_W-1:0] found_mac;
  } result_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    logic [IP_W-1:0]  wip;
    logic [MAC_W-1:0] wmac;
    logic [IDX_W-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    logic [IP_W-1:0]  ip;
    logic [MAC_W-1:0] mac;
  } mem_rd_t;

endpackage

>>> design/arpc_if.sv
interface arpc_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [15:0] rx_operation;
  logic [47:0] rx_sender_mac;
  logic [31:0] rx_sender_ip;
  logic [31:0] rx_target_ip;
  logic [31:0] lookup_ip;
  logic [31:0] request_ip;

  modport source (
    output valid, opcode, rx_operation, rx_sender_mac, rx_sender_ip, rx_target_ip,
           lookup_ip, request_ip,
    input  ready
  );
  modport sink (
    input  valid, opcode, rx_operation, rx_sender_mac, rx_sender_ip, rx_target_ip,
           lookup_ip, request_ip,
    output ready
  );
endinterface

interface arpc_out_if;
  logic        valid;
  logic        ready;
  logic        send_frame;
  logic [1:0]  frame_operation;
  logic [47:0] frame_dest_mac;
  logic [47:0] frame_target_mac;
  logic [31:0] frame_target_ip;
  logic        found;
  logic [47:0] found_mac;

  modport source (
    output valid, send_frame, frame_operation, frame_dest_mac, frame_target_mac,
           frame_target_ip, found, found_mac,
    input  ready
  );
  modport sink (
    input  valid, send_frame, frame_operation, frame_dest_mac, frame_target_mac,
           frame_target_ip, found, found_mac,
    output ready
  );
endinterface

interface arpc_cfg_if;
  logic        valid;
  logic        ready;
  logic [0:0]  index;
  logic [47:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> design/arpc_cache_mem.sv
module arpc_cache_mem
  import arpc_pkg::*;
(
  input  logic     clk,
  input  mem_req_t req,
  output mem_rd_t  rd
);

  logic [IP_W-1:0]  ip_mem  [CACHE_ENTRIES];
  logic [MAC_W-1:0] mac_mem [CACHE_ENTRIES];

  always_ff @(posedge clk) begin
    if (req.we) begin
      ip_mem[req.waddr]  <= req.wip;
      mac_mem[req.waddr] <= req.wmac;
    end
  end

  // registered read
  always_ff @(posedge clk) begin
    rd.ip  <= ip_mem[req.raddr];
    rd.mac <= mac_mem[req.raddr];
  end

endmodule

>>> design/arpc_engine.sv
module arpc_engine
  import arpc_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  arpc_in_if.sink      in_ch,
  arpc_out_if.source   out_ch,
  output mem_req_t     mem_req,
  input  mem_rd_t      mem_rd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]       state, state_next;
  logic [CNT_W-1:0] count, count_next;
  logic [IDX_W-1:0] scan_idx, scan_idx_next;
  logic [IP_W-1:0]  look_ip, look_ip_next;
  result_t          res, res_next;
  logic             out_valid, out_valid_next;
  result_t          out_data, out_data_next;

  assign in_ch.ready = (state == ST_IDLE);

  always_comb begin
    state_next     = state;
    count_next     = count;
    scan_idx_next  = scan_idx;
    look_ip_next   = look_ip;
    res_next       = res;
    out_data_next  = out_data;
    out_valid_next = out_valid;
    if (out_valid && out_ch.ready) begin
      out_valid_next = 1'b0;
    end

    mem_req.we    = 1'b0;
    mem_req.waddr = count[IDX_W-1:0];
    mem_req.wip   = in_ch.rx_sender_ip;
    mem_req.wmac  = in_ch.rx_sender_mac;
    mem_req.raddr = '0;

    case (state)
      ST_IDLE: begin
        if (in_ch.valid) begin
          res_next      = '0;
          scan_idx_next = '0;
          state_next    = ST_DONE;
          case (in_ch.opcode)
            OP_RX: begin
              if (in_ch.rx_operation == RX_ARP_REQUEST) begin
                res_next.send_frame       = 1'b1;
                res_next.frame_operation  = FR_REPLY;
                res_next.frame_dest_mac   = in_ch.rx_sender_mac;
                res_next.frame_target_mac = in_ch.rx_sender_mac;
                res_next.frame_target_ip  = in_ch.rx_sender_ip;
              end else if (in_ch.rx_operation == RX_ARP_REPLY &&
                           count < CNT_W'(CACHE_ENTRIES)) begin
                // append; full cache drops silently
                mem_req.we = 1'b1;
                count_next = count + CNT_W'(1);
              end
            end
            OP_LOOKUP: begin
              look_ip_next = in_ch.lookup_ip;
              if (count != '0) begin
                state_next = ST_SCAN;
              end
            end
            OP_SEND_REQ: begin
              res_next.send_frame      = 1'b1;
              res_next.frame_operation = FR_REQUEST;
              res_next.frame_dest_mac  = MAC_BROADCAST;
              res_next.frame_target_ip = in_ch.request_ip;
            end
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        // mem_rd holds entry scan_idx
        if (mem_rd.ip == look_ip) begin
          res_next.found     = 1'b1;
          res_next.found_mac = mem_rd.mac;
          state_next         = ST_DONE;
        end else if (CNT_W'(scan_idx) + CNT_W'(1) < count) begin
          mem_req.raddr = scan_idx + IDX_W'(1);
          scan_idx_next = scan_idx + IDX_W'(1);
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid || out_ch.ready) begin
          out_valid_next = 1'b1;
          out_data_next  = res;
          state_next     = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      out_valid <= out_valid_next;
    end
    scan_idx <= scan_idx_next;
    look_ip  <= look_ip_next;
    res      <= res_next;
    out_data <= out_data_next;
  end

  assign out_ch.valid            = out_valid;
  assign out_ch.send_frame       = out_data.send_frame;
  assign out_ch.frame_operation  = out_data.frame_operation;
  assign out_ch.frame_dest_mac   = out_data.frame_dest_mac;
  assign out_ch.frame_target_mac = out_data.frame_target_mac;
  assign out_ch.frame_target_ip  = out_data.frame_target_ip;
  assign out_ch.found            = out_data.found;
  assign out_ch.found_mac        = out_data.found_mac;

endmodule

>>> design/arp_cache_and_responder.sv
// ARP responder with an eight-entry address cache. One item is handled at a
// time: in_ch.ready is high only while the sequencer is idle. A received
// request gives a reply frame aimed at the requester, a received reply is
// appended to the cache (dropped when full, duplicates kept), a lookup scans
// the cache from entry 0 and returns the first match, and a send-request
// item gives a broadcast request. Every item produces exactly one result
// transfer. Timing: all items but lookups go from acceptance straight to
// the load of the result into the output register. A lookup first reads
// the cache one entry per cycle, because the cache has a single registered
// read port, and a hit stops the scan early. The sequencer is back in idle
// right after the load; any wait for the output register to free up adds to
// the time an item takes. The next item is taken the cycle after the result
// is loaded into the output register, even while that result waits.
// own_mac / own_ip (config index 0 / 1) are held here for the downstream
// framer as the sender fields; write them only while the block is idle.
module arp_cache_and_responder
  import arpc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  arpc_cfg_if.sink    cfg_ch,
  arpc_in_if.sink     in_ch,
  arpc_out_if.source  out_ch
);

  logic [MAC_W-1:0] own_mac;
  logic [IP_W-1:0]  own_ip;

  mem_req_t mem_req;
  mem_rd_t  mem_rd;

  // config writes always taken
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      own_mac <= '0;
      own_ip  <= '0;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        CFG_OWN_MAC: own_mac <= cfg_ch.data;
        CFG_OWN_IP:  own_ip  <= cfg_ch.data[IP_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer: decode, append, lookup scan, output register.
  // Appends and scans never overlap (one item in flight), so no forwarding.
  arpc_engine u_engine (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .mem_req (mem_req),
    .mem_rd  (mem_rd)
  );

  // Cache storage: entry IP and MAC, one write and one registered read port.
  arpc_cache_mem u_cache (
    .clk (clk),
    .req (mem_req),
    .rd  (mem_rd)
  );

endmodule

>>> bench/arpc_scoreboard.sv
`timescale 1ns / 1ps
module arpc_scoreboard
  import arpc_pkg::*;
(
  input  logic clk,
  input  logic rst,
  arpc_cfg_if  cfg_ch,
  arpc_in_if   in_ch,
  arpc_out_if  out_ch,
  output int   mismatches,
  output int   outstanding
);

  typedef struct packed {
    logic [1:0]       opcode;
    logic [15:0]      rx_operation;
    logic [MAC_W-1:0] rx_sender_mac;
    logic [IP_W-1:0]  rx_sender_ip;
    logic [IP_W-1:0]  rx_target_ip;
    logic [IP_W-1:0]  lookup_ip;
    logic [IP_W-1:0]  request_ip;
  } arp_item_t;

  // shadow copy of the block's state
  logic [IP_W-1:0]  cache_ip[CACHE_ENTRIES];
  logic [MAC_W-1:0] cache_mac[CACHE_ENTRIES];
  int               cache_used;
  // sender identity; goes to the framer, never into the result
  logic [MAC_W-1:0] sender_mac;
  logic [IP_W-1:0]  sender_ip;

  result_t   awaited_results[$];
  result_t   got;
  result_t   want;
  arp_item_t item;

  function automatic result_t resolve_arp_item(arp_item_t it);
    result_t r;
    r = '0;
    case (it.opcode)
      OP_RX: begin
        if (it.rx_operation == RX_ARP_REQUEST) begin
          r.send_frame       = 1'b1;
          r.frame_operation  = FR_REPLY;
          r.frame_dest_mac   = it.rx_sender_mac;
          r.frame_target_mac = it.rx_sender_mac;
          r.frame_target_ip  = it.rx_sender_ip;
        end else if (it.rx_operation == RX_ARP_REPLY && cache_used < CACHE_ENTRIES) begin
          cache_ip[cache_used]  = it.rx_sender_ip;
          cache_mac[cache_used] = it.rx_sender_mac;
          cache_used++;
        end
      end
      OP_LOOKUP: begin
        // lowest index wins
        for (int i = 0; i < cache_used; i++) begin
          if (!r.found && cache_ip[i] == it.lookup_ip) begin
            r.found     = 1'b1;
            r.found_mac = cache_mac[i];
          end
        end
      end
      OP_SEND_REQ: begin
        r.send_frame       = 1'b1;
        r.frame_operation  = FR_REQUEST;
        r.frame_dest_mac   = MAC_BROADCAST;
        r.frame_target_mac = '0;
        r.frame_target_ip  = it.request_ip;
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic void check_field(string field, logic [63:0] exp_v, logic [63:0] act_v);
    if (act_v !== exp_v) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t %s mismatch: expected %0h, got %0h", $time, field, exp_v, act_v);
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      cache_used = 0;
      sender_mac = '0;
      sender_ip  = '0;
      awaited_results.delete();
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          CFG_OWN_MAC: sender_mac = cfg_ch.data;
          CFG_OWN_IP:  sender_ip  = cfg_ch.data[IP_W-1:0];
          default: ;
        endcase
      end
      // retire before queueing: a result can never belong to an item taken the same edge
      if (out_ch.valid && out_ch.ready) begin
        got = {out_ch.send_frame, out_ch.frame_operation, out_ch.frame_dest_mac,
               out_ch.frame_target_mac, out_ch.frame_target_ip, out_ch.found,
               out_ch.found_mac};
        if (awaited_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t result transfer with nothing outstanding", $time);
        end else begin
          want = awaited_results.pop_front();
          check_field("send_frame",       want.send_frame,       got.send_frame);
          check_field("frame_operation",  want.frame_operation,  got.frame_operation);
          check_field("frame_dest_mac",   want.frame_dest_mac,   got.frame_dest_mac);
          check_field("frame_target_mac", want.frame_target_mac, got.frame_target_mac);
          check_field("frame_target_ip",  want.frame_target_ip,  got.frame_target_ip);
          check_field("found",            want.found,            got.found);
          check_field("found_mac",        want.found_mac,        got.found_mac);
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        item = {in_ch.opcode, in_ch.rx_operation, in_ch.rx_sender_mac, in_ch.rx_sender_ip,
                in_ch.rx_target_ip, in_ch.lookup_ip, in_ch.request_ip};
        awaited_results.push_back(resolve_arp_item(item));
      end
    end
    outstanding <= awaited_results.size();
  end

endmodule

>>> bench/tb.sv
`timescale 1ns / 1ps
module tb;
  import arpc_pkg::*;

  logic clk = 1'b0;
  logic rst;

  // idle rates in percent; changed per phase
  int send_gap_pct;
  int recv_stall_pct;

  int mismatches;
  int outstanding;

  // every sender IP ever offered in a reply, so lookups can aim at the cache
  logic [IP_W-1:0] offered_ips[$];

  arpc_cfg_if cfg_ch();
  arpc_in_if  in_ch();
  arpc_out_if out_ch();

  arp_cache_and_responder dut (
    .clk    (clk),
    .rst    (rst),
    .cfg_ch (cfg_ch),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // checker watches all three channels and keeps the failure count
  arpc_scoreboard chk (
    .clk         (clk),
    .rst         (rst),
    .cfg_ch      (cfg_ch),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always #2 clk = ~clk;

  // result side back-pressure, redrawn every cycle
  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // hard stop in case a handshake never completes
  initial begin
    #2000000;
    $display("tb NOT OK");
    $finish;
  end

  function automatic logic [MAC_W-1:0] rand_mac();
    logic [63:0] w;
    w = {$urandom(), $urandom()};
    return w[MAC_W-1:0];
  endfunction

  function automatic logic [IP_W-1:0] rand_ip();
    return $urandom();
  endfunction

  // Both sender fields go through one write each; valid stays up between the
  // two transfers so it is never dropped and raised in the same step.
  // Upper data bits on the IP write are junk the block must ignore.
  task automatic set_identity(input logic [MAC_W-1:0] mac, input logic [IP_W-1:0] ip);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= CFG_OWN_MAC;
    cfg_ch.data  <= mac;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.index <= CFG_OWN_IP;
    cfg_ch.data  <= {16'($urandom()), ip};
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
  endtask

  // One item transfer. Valid is left high afterwards; it only drops when the
  // sender takes a gap or at a drain, so back-to-back items keep it steady.
  // The sender idles each cycle with the gap percentage before presenting.
  task automatic send_arp(input logic [1:0] op, input logic [15:0] rx_op,
                          input logic [MAC_W-1:0] mac, input logic [IP_W-1:0] sip,
                          input logic [IP_W-1:0] tip, input logic [IP_W-1:0] lip,
                          input logic [IP_W-1:0] rip);
    while ($urandom_range(99) < send_gap_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.opcode        <= op;
    in_ch.rx_operation  <= rx_op;
    in_ch.rx_sender_mac <= mac;
    in_ch.rx_sender_ip  <= sip;
    in_ch.rx_target_ip  <= tip;
    in_ch.lookup_ip     <= lip;
    in_ch.request_ip    <= rip;
    if (op == OP_RX && rx_op == RX_ARP_REPLY) offered_ips.push_back(sip);
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // shorthand for the common shapes; unused fields get random filler
  task automatic send_rx(input logic [15:0] rx_op, input logic [MAC_W-1:0] mac,
                         input logic [IP_W-1:0] sip);
    send_arp(OP_RX, rx_op, mac, sip, rand_ip(), rand_ip(), rand_ip());
  endtask

  task automatic send_lookup(input logic [IP_W-1:0] ip);
    send_arp(OP_LOOKUP, 16'($urandom()), rand_mac(), rand_ip(), rand_ip(), ip, rand_ip());
  endtask

  task automatic send_request(input logic [IP_W-1:0] ip);
    send_arp(OP_SEND_REQ, 16'($urandom()), rand_mac(), rand_ip(), rand_ip(), rand_ip(), ip);
  endtask

  // Wait until every queued result has come back. The first edge lets the
  // checker's count catch up with the item just taken.
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic random_item();
    int pick;
    int sel;
    logic [IP_W-1:0] ip;
    pick = $urandom_range(99);
    sel  = $urandom_range(99);
    if (pick < 35) begin
      // received packet: mostly requests and replies, some other operations
      if (sel < 45)      send_rx(RX_ARP_REQUEST, rand_mac(), rand_ip());
      else if (sel < 85) send_rx(RX_ARP_REPLY, rand_mac(), rand_ip());
      else               send_rx(16'($urandom()), rand_mac(), rand_ip());
    end else if (pick < 70) begin
      // lookups lean toward addresses that were offered to the cache
      if (sel < 70 && offered_ips.size() != 0)
        ip = offered_ips[$urandom_range(offered_ips.size() - 1)];
      else if (sel < 80)
        ip = (sel[0]) ? '1 : '0;
      else
        ip = rand_ip();
      send_lookup(ip);
    end else if (pick < 95) begin
      send_request((sel < 10) ? '1 : (sel < 20) ? '0 : rand_ip());
    end else begin
      // unused opcode, must give an all-zero result
      send_arp(2'd3, 16'($urandom()), rand_mac(), rand_ip(), rand_ip(), rand_ip(), rand_ip());
    end
  endtask

  initial begin
    logic [IP_W-1:0] last_ip;
    rst = 1'b1;
    send_gap_pct   = 27;
    recv_stall_pct = 71;
    out_ch.ready   = 1'b0;
    cfg_ch.valid   = 1'b0;
    cfg_ch.index   = '0;
    cfg_ch.data    = '0;
    in_ch.valid         = 1'b0;
    in_ch.opcode        = '0;
    in_ch.rx_operation  = '0;
    in_ch.rx_sender_mac = '0;
    in_ch.rx_sender_ip  = '0;
    in_ch.rx_target_ip  = '0;
    in_ch.lookup_ip     = '0;
    in_ch.request_ip    = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    set_identity('1, '0);

    // ---- directed ----
    send_lookup(32'h0A00_0001);              // empty cache: miss
    send_rx(RX_ARP_REPLY, '1, '0);           // entry 0
    send_rx(RX_ARP_REPLY, '0, '1);           // entry 1
    send_rx(RX_ARP_REPLY, 48'h0200_5E00_0001, '0); // duplicate IP, entry 2
    send_lookup('0);                         // duplicate: lowest index wins
    send_lookup('1);                         // hit with all-zero MAC
    send_lookup(32'hDEAD_BEEF);              // miss with entries present
    send_rx(RX_ARP_REQUEST, '1, '1);         // reply to extreme requester
    send_rx(RX_ARP_REQUEST, '0, '0);
    send_request('0);                        // broadcast request extremes
    send_request('1);
    send_rx(16'h0000, rand_mac(), rand_ip()); // unknown operations ignored
    send_rx(16'h0003, rand_mac(), rand_ip());
    send_rx(16'hFFFF, rand_mac(), rand_ip());
    send_rx(16'h0100, rand_mac(), rand_ip()); // request in wrong byte order
    send_arp(2'd3, RX_ARP_REQUEST, rand_mac(), rand_ip(), rand_ip(), rand_ip(), rand_ip());
    // fill the remaining five entries
    repeat (5) begin
      last_ip = rand_ip();
      send_rx(RX_ARP_REPLY, rand_mac(), last_ip);
    end
    send_rx(RX_ARP_REPLY, rand_mac(), 32'hC0A8_0063); // cache full: dropped
    send_lookup(32'hC0A8_0063);              // dropped entry must miss
    send_lookup(last_ip);                    // hit in the last slot
    drain();

    // ---- random, three idling regimes ----
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          send_gap_pct   = 27;
          recv_stall_pct = 71;
          set_identity(rand_mac(), rand_ip());
        end
        1: begin
          send_gap_pct   = 71;
          recv_stall_pct = 27;
          set_identity('0, '1);
        end
        default: begin
          send_gap_pct   = 0;
          recv_stall_pct = 0;
          set_identity(rand_mac(), rand_ip());
        end
      endcase
      repeat (234) random_item();
      drain();
    end

    // leave room for a stray transfer
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
